>>> sv/csu_pkg.sv
// shared types and constants for the can signal unpack block
`timescale 1ns / 1ps

package csu_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 8;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned PADDR_W         = 6;
  localparam int unsigned PDATA_W         = 64;
  localparam int unsigned SCALE_W         = 32;
  localparam int unsigned OFFSET_W        = 48;
  localparam int unsigned REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_BIT    = 3'd0,
    REG_BIT_LENGTH   = 3'd1,
    REG_BIG_ENDIAN   = 3'd2,
    REG_SIGNED_VALUE = 3'd3,
    REG_SCALE_FACTOR = 3'd4,
    REG_OFFSET_VALUE = 3'd5
  } reg_idx_e;

  localparam logic [5:0]          START_BIT_RST  = 6'd0;
  localparam logic [6:0]          BIT_LENGTH_RST = 7'd8;
  localparam logic [SCALE_W-1:0]  SCALE_RST      = 32'h0100_0000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST     = '0;

  typedef struct packed {
    logic [5:0] start_bit;
    logic [6:0] bit_length;
    logic       big_endian;
    logic       signed_value;
  } cfg_t;

endpackage

>>> sv/csu_extract.sv
// field extraction with intel or motorola layout, mask and sign extension
`timescale 1ns / 1ps

module csu_extract #(
  parameter int unsigned FRAME_BYTES = csu_pkg::FRAME_BYTES_DEF
) (
  input  logic [8*FRAME_BYTES-1:0]  frame_i,
  input  csu_pkg::cfg_t             cfg_i,
  output logic [csu_pkg::DATA_W-1:0] raw_o,
  output logic                      rneg_o
);
  import csu_pkg::*;

  logic [DATA_W-1:0] data;
  logic [DATA_W-1:0] swapped;
  logic [DATA_W-1:0] field;
  logic [6:0]        len;
  logic [5:0]        msb_pos;
  logic [6:0]        msb_cnt;
  logic [5:0]        top_idx;
  logic              do_sext;

  function automatic logic [DATA_W-1:0] low_mask(input logic [6:0] n);
    if (n >= 7'd64) begin
      return '1;
    end
    return (64'd1 << n[5:0]) - 64'd1;
  endfunction

  always_comb begin
    // bytes past the payload read as zero
    data = DATA_W'(frame_i);
    for (int i = 0; i < 8; i++) begin
      swapped[8*(7-i) +: 8] = data[8*i +: 8];
    end

    len     = (cfg_i.bit_length > 7'd64) ? 7'd64 : cfg_i.bit_length;
    msb_pos = {~cfg_i.start_bit[5:3], cfg_i.start_bit[2:0]};
    msb_cnt = {1'b0, msb_pos} + 7'd1;

    if (len == 7'd0) begin
      field = '0;
    end else if (!cfg_i.big_endian) begin
      field = (data >> cfg_i.start_bit) & low_mask(len);
    end else if (msb_cnt >= len) begin
      field = (swapped >> (msb_cnt - len)) & low_mask(len);
    end else begin
      // field runs off the end of the payload: pad with zeros at the bottom
      field = (swapped & low_mask(msb_cnt)) << (len - msb_cnt);
    end

    top_idx = 6'(len - 7'd1);
    do_sext = cfg_i.signed_value && (len != 7'd0) && (len < 7'd64) && field[top_idx];
    raw_o   = do_sext ? (field | ~low_mask(len)) : field;
    rneg_o  = cfg_i.signed_value && (len != 7'd0) && raw_o[DATA_W-1];
  end

endmodule

>>> sv/csu_phys.sv
// partial product sum, rounding to q.16, offset and saturation
`timescale 1ns / 1ps

module csu_phys (
  input  logic signed [64:0]                pp_lo_i,
  input  logic signed [64:0]                pp_hi_i,
  input  logic [csu_pkg::OFFSET_W-1:0]      offset_i,
  output logic [csu_pkg::DATA_W-1:0]        phys_o,
  output logic                              sat_o
);
  import csu_pkg::*;

  logic [96:0] t_hi;
  logic [96:0] t_lo;
  logic [96:0] t_off;
  logic [96:0] t_sum;
  logic [88:0] q;

  always_comb begin
    t_hi  = {pp_hi_i, 32'd0};
    t_lo  = {{32{pp_lo_i[64]}}, pp_lo_i};
    // offset lifted to q.24 so the round and the offset share one add
    t_off = {{41{offset_i[OFFSET_W-1]}}, offset_i, 8'd0};
    t_sum = t_hi + t_lo + t_off + 97'd128;
    q     = t_sum[96:8];

    sat_o = (q[88:63] != {26{q[63]}});
    if (sat_o) begin
      phys_o = q[88] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      phys_o = q[63:0];
    end
  end

endmodule

>>> sv/can_signal_unpack.sv
// top level of the can signal unpack block
//
//  port group  dir  handshake                 payload
//  in          in   in_valid_i / in_stall_o   frame_data_i
//  out         out  out_valid_o / out_stall_i raw_value_o, physical_value_o, saturated_o
//  cfg         in   apb psel/penable/pready   paddr, pwdata, prdata
//
// four register stages: frame, extracted field, partial products, result
// one item per cycle sustained while out_stall_i is low; an accepted item moves through the frame,
// field, partial product and result registers in order and leaves while out_valid_o is high
// the multiply is split over the two 32-bit halves of the field; the two partial products are summed in the last stage
// a stall on the output backs up stage by stage; empty stages keep filling
// reset clears the stage valid bits and loads the register defaults
`timescale 1ns / 1ps

module can_signal_unpack #(
  parameter int unsigned FRAME_BYTES = csu_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csu_pkg::PADDR_W-1:0]   paddr,
  input  logic [csu_pkg::PDATA_W-1:0]   pwdata,
  output logic [csu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   frame_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   raw_value_o,
  output logic signed [63:0]            physical_value_o,
  output logic                          saturated_o
);
  import csu_pkg::*;

  localparam int unsigned FRAME_W = 8 * FRAME_BYTES;

  // configuration registers
  cfg_t                cfg_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                wr_en;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_bit    <= START_BIT_RST;
      cfg_q.bit_length   <= BIT_LENGTH_RST;
      cfg_q.big_endian   <= 1'b0;
      cfg_q.signed_value <= 1'b0;
      scale_q            <= SCALE_RST;
      offset_q           <= OFFSET_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_BIT:    cfg_q.start_bit    <= pwdata[5:0];
        REG_BIT_LENGTH:   cfg_q.bit_length   <= pwdata[6:0];
        REG_BIG_ENDIAN:   cfg_q.big_endian   <= pwdata[0];
        REG_SIGNED_VALUE: cfg_q.signed_value <= pwdata[0];
        REG_SCALE_FACTOR: scale_q            <= pwdata[SCALE_W-1:0];
        REG_OFFSET_VALUE: offset_q           <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_BIT:    prdata = PDATA_W'(cfg_q.start_bit);
      REG_BIT_LENGTH:   prdata = PDATA_W'(cfg_q.bit_length);
      REG_BIG_ENDIAN:   prdata = PDATA_W'(cfg_q.big_endian);
      REG_SIGNED_VALUE: prdata = PDATA_W'(cfg_q.signed_value);
      REG_SCALE_FACTOR: prdata = PDATA_W'(scale_q);
      REG_OFFSET_VALUE: prdata = PDATA_W'(offset_q);
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  assign ld4        = !v4_q || !out_stall_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_stall_o = !ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // stage 1: frame
  logic [FRAME_W-1:0] frame_q;

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) frame_q <= frame_data_i[FRAME_W-1:0];
  end

  // stage 2: extracted field
  logic [DATA_W-1:0] raw_d, raw2_q, raw3_q;
  logic              rneg_d, rneg2_q;

  csu_extract #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_extract (
    .frame_i(frame_q),
    .cfg_i  (cfg_q),
    .raw_o  (raw_d),
    .rneg_o (rneg_d)
  );

  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q) begin
      raw2_q  <= raw_d;
      rneg2_q <= rneg_d;
    end
  end

  // stage 3: partial products of the 65-bit signed field and the scale
  logic signed [64:0] pp_lo_d, pp_hi_d, pp_lo_q, pp_hi_q;

  assign pp_lo_d = $signed({1'b0, raw2_q[31:0]}) * $signed(scale_q);
  assign pp_hi_d = $signed({rneg2_q, raw2_q[63:32]}) * $signed(scale_q);

  always_ff @(posedge clk_i) begin
    if (ld3 && v2_q) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      raw3_q  <= raw2_q;
    end
  end

  // stage 4: result
  logic [DATA_W-1:0] phys_d, phys_q, raw4_q;
  logic              sat_d, sat_q;

  csu_phys u_phys (
    .pp_lo_i (pp_lo_q),
    .pp_hi_i (pp_hi_q),
    .offset_i(offset_q),
    .phys_o  (phys_d),
    .sat_o   (sat_d)
  );

  always_ff @(posedge clk_i) begin
    if (ld4 && v3_q) begin
      raw4_q <= raw3_q;
      phys_q <= phys_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o      = v4_q;
  assign raw_value_o      = raw4_q;
  assign physical_value_o = $signed(phys_q);
  assign saturated_o      = sat_q;

endmodule

>>> sv/csu_chk.sv
// port-level checks for the can signal unpack block, bound to the top level
`timescale 1ns / 1ps

module csu_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              pready,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [63:0]       raw_value_o,
  input logic signed [63:0] physical_value_o,
  input logic              saturated_o
);

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_value_o)
      && $stable(physical_value_o) && $stable(saturated_o))
    else $error("stalled output item changed");

  // a clipped result sits at one of the two range ends
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (physical_value_o == 64'sh7FFF_FFFF_FFFF_FFFF) ||
      (physical_value_o == 64'sh8000_0000_0000_0000))
    else $error("saturated flag with unclipped value");

  // with an empty output stage the pipeline can always take an item
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  // register access never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |-> pready)
    else $error("apb write held off");

endmodule

bind can_signal_unpack csu_chk u_csu_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .raw_value_o     (raw_value_o),
  .physical_value_o(physical_value_o),
  .saturated_o     (saturated_o)
);

>>> tb/can_signal_unpack_test.sv
// testbench for the can signal unpack block: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module can_signal_unpack_test;
  import csu_pkg::*;

  localparam int unsigned PIPE_LATENCY = 4;

  typedef struct packed {
    logic [63:0]        raw;
    logic signed [63:0] phys;
    logic               sat;
  } signal_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [63:0]         frame_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [63:0]         raw_value_o;
  logic signed [63:0]  physical_value_o;
  logic                saturated_o;

  // predictor copy of the register file
  logic [5:0]          cfg_start;
  logic [6:0]          cfg_len;
  logic                cfg_big_endian;
  logic                cfg_signed;
  logic [31:0]         cfg_scale;
  logic [47:0]         cfg_offset;

  signal_result_t      pending_signals_q[$];
  int unsigned         mismatch_count;
  bit                  tx_idle_on;
  bit                  rx_idle_on;
  int unsigned         rx_hold_req;

  can_signal_unpack uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_data_i     (frame_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .raw_value_o      (raw_value_o),
    .physical_value_o (physical_value_o),
    .saturated_o      (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mask_bits(int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // extract, sign extend, scale and offset one frame with the current settings
  function automatic signal_result_t decode_signal(logic [63:0] frame);
    int unsigned         len;
    int unsigned         s;
    int unsigned         m;
    int unsigned         i;
    logic [63:0]         raw;
    logic [63:0]         swapped;
    logic                rneg;
    logic [127:0]        raw_wide;
    logic [127:0]        scale_wide;
    logic signed [127:0] acc;
    logic signed [127:0] off_wide;
    signal_result_t      r;
    len = 32'(cfg_len);
    if (len > 64) len = 64;
    s = 32'(cfg_start);
    if (len == 0) begin
      raw = '0;
    end else if (!cfg_big_endian) begin
      raw = (frame >> s) & mask_bits(len);
    end else begin
      // motorola: byte-reverse so the sawtooth becomes one downward run
      for (i = 0; i < 8; i++) swapped[8*(7-i) +: 8] = frame[8*i +: 8];
      m = (7 - s / 8) * 8 + s % 8;
      if (m + 1 >= len) raw = (swapped >> (m + 1 - len)) & mask_bits(len);
      else raw = (swapped & mask_bits(m + 1)) << (len - 1 - m);
    end
    if (cfg_signed && len > 0 && len < 64 && raw[len-1]) raw = raw | ~mask_bits(len);
    rneg = cfg_signed && len > 0 && raw[63];
    raw_wide = {{64{rneg}}, raw};
    scale_wide = {{96{cfg_scale[31]}}, cfg_scale};
    acc = raw_wide * scale_wide;
    // q.24 to q.16, ties toward positive infinity
    acc = (acc + 128) >>> 8;
    off_wide = {{80{cfg_offset[47]}}, cfg_offset};
    acc = acc + off_wide;
    r.raw = raw;
    if (acc[127:63] != {65{acc[127]}}) begin
      r.sat  = 1'b1;
      r.phys = acc[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r.sat  = 1'b0;
      r.phys = acc[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] random_frame();
    logic [63:0] bit_sel;
    bit_sel = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return bit_sel;
      3:       return ~bit_sel;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_frame(logic [63:0] frame);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i   <= 1'b0;
      frame_data_i <= {$urandom, $urandom};
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    frame_data_i <= frame;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_signals_q.push_back(decode_signal(frame));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_signals_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // unused upper data bits carry junk, the register keeps only its own width
  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    int unsigned width;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    case (idx)
      REG_START_BIT:    width = 6;
      REG_BIT_LENGTH:   width = 7;
      REG_BIG_ENDIAN:   width = 1;
      REG_SIGNED_VALUE: width = 1;
      REG_SCALE_FACTOR: width = SCALE_W;
      default:          width = OFFSET_W;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= (junk & ~mask_bits(width)) | (value & mask_bits(width));
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_START_BIT:    cfg_start      = value[5:0];
      REG_BIT_LENGTH:   cfg_len        = value[6:0];
      REG_BIG_ENDIAN:   cfg_big_endian = value[0];
      REG_SIGNED_VALUE: cfg_signed     = value[0];
      REG_SCALE_FACTOR: cfg_scale      = value[31:0];
      default:          cfg_offset     = value[47:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_signal(int unsigned start, int unsigned len, bit big_endian,
                            bit is_signed, logic [31:0] scale, logic [47:0] offset);
    wait_drained();
    write_reg(REG_START_BIT, 64'(start));
    write_reg(REG_BIT_LENGTH, 64'(len));
    write_reg(REG_BIG_ENDIAN, 64'(big_endian));
    write_reg(REG_SIGNED_VALUE, 64'(is_signed));
    write_reg(REG_SCALE_FACTOR, 64'(scale));
    write_reg(REG_OFFSET_VALUE, 64'(offset));
  endtask

  task automatic test_reset_defaults();
    send_frame(64'h0123_4567_89AB_CDEF);
    send_frame('1);
  endtask

  task automatic test_intel_layout();
    // single top bit, signed: reads as minus one
    set_signal(63, 1, 1'b0, 1'b1, 32'h0100_0000, '0);
    send_frame(64'h8000_0000_0000_0000);
    send_frame(64'h7FFF_FFFF_FFFF_FFFF);
    // full width unsigned times one overflows the result range
    set_signal(0, 64, 1'b0, 1'b0, 32'h0100_0000, '0);
    send_frame('1);
    // field runs past byte 7, upper bits read as zero
    set_signal(60, 8, 1'b0, 1'b1, 32'h0100_0000, '0);
    send_frame('1);
  endtask

  task automatic test_motorola_layout();
    set_signal(7, 64, 1'b1, 1'b0, 32'h0000_0100, '0);
    send_frame(64'h0123_4567_89AB_CDEF);
    set_signal(0, 64, 1'b1, 1'b1, 32'h0100_0000, '0);
    send_frame('1);
    set_signal(63, 1, 1'b1, 1'b0, 32'h0100_0000, '0);
    send_frame(64'h8000_0000_0000_0000);
    set_signal(56, 16, 1'b1, 1'b1, 32'hFF00_0000, 48'h0000_0001_0000);
    send_frame(64'h0100_0000_0000_0000);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_length_edges();
    set_signal(5, 0, 1'b0, 1'b1, 32'h0100_0000, 48'h0000_0002_8000);
    send_frame('1);
    set_signal(0, 127, 1'b0, 1'b1, 32'h0100_0000, '0);
    send_frame(64'h8000_0000_0000_0001);
    set_signal(63, 65, 1'b1, 1'b0, 32'h0000_0001, '0);
    send_frame(64'h00FF_0000_0000_0080);
  endtask

  task automatic test_scaling_limits();
    set_signal(0, 64, 1'b0, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_frame('1);
    set_signal(0, 64, 1'b0, 1'b0, 32'h8000_0000, 48'h8000_0000_0000);
    send_frame('1);
    // rounding ties: +0.5 lsb rounds up, -0.5 lsb rounds toward zero
    set_signal(0, 1, 1'b0, 1'b0, 32'h0000_0080, '0);
    send_frame(64'h1);
    set_signal(0, 1, 1'b0, 1'b1, 32'h0000_0080, '0);
    send_frame(64'h1);
    set_signal(8, 16, 1'b0, 1'b1, 32'h0000_0000, 48'h8000_0000_0000);
    send_frame(64'h0000_0000_00FF_FF00);
    set_signal(0, 32, 1'b0, 1'b1, 32'h8000_0000, 48'h7FFF_FFFF_FFFF);
    send_frame(64'h0000_0000_8000_0000);
  endtask

  task automatic test_random_signals(int unsigned phases, int unsigned frames_per_phase);
    int unsigned start;
    int unsigned len;
    logic [31:0] scale;
    logic [63:0] offset_bits;
    repeat (phases) begin
      case ($urandom_range(0, 3))
        0:       start = $urandom_range(0, 1) ? 63 : 0;
        default: start = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = 64;
        2:       len = 0;
        3:       len = $urandom_range(65, 127);
        default: len = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 7))
        0:       scale = 32'h7FFF_FFFF;
        1:       scale = 32'h8000_0000;
        2:       scale = '0;
        3:       scale = 32'h0100_0000;
        4:       scale = -32'sh0100_0000;
        default: scale = $urandom;
      endcase
      offset_bits = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       offset_bits = 64'h7FFF_FFFF_FFFF;
        1:       offset_bits = 64'h8000_0000_0000;
        2:       offset_bits = '0;
        default: ;
      endcase
      set_signal(start, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), scale,
                 offset_bits[47:0]);
      // some phases run without any idling on one or both sides
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (frames_per_phase) send_frame(random_frame());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_signal(4, 20, 1'b1, 1'b1, 32'h0080_0000, 48'h0000_0010_0000);
    tx_idle_on  = 1'b0;
    rx_hold_req = 80;
    repeat (40) send_frame(random_frame());
    tx_idle_on  = 1'b1;
  endtask

  // result sink: random stall per item, long hold on request
  initial begin
    int unsigned hold_cycles;
    out_stall_i = 1'b0;
    forever begin
      if (rx_hold_req != 0) begin
        hold_cycles = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold_cycles = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      repeat (hold_cycles) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  initial begin
    signal_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_signals_q.size() == 0) begin
          $error("unexpected result: raw_value %h physical_value %h", raw_value_o,
                 physical_value_o);
          mismatch_count++;
        end else begin
          want = pending_signals_q.pop_front();
          if (raw_value_o !== want.raw) begin
            $error("raw_value: expected %h, got %h", want.raw, raw_value_o);
            mismatch_count++;
          end
          if (physical_value_o !== want.phys) begin
            $error("physical_value: expected %h, got %h", want.phys, physical_value_o);
            mismatch_count++;
          end
          if (saturated_o !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, saturated_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    frame_data_i   = '0;
    mismatch_count = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_req    = 0;
    cfg_start      = START_BIT_RST;
    cfg_len        = BIT_LENGTH_RST;
    cfg_big_endian = 1'b0;
    cfg_signed     = 1'b0;
    cfg_scale      = SCALE_RST;
    cfg_offset     = OFFSET_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_intel_layout();
    test_motorola_layout();
    test_length_edges();
    test_scaling_limits();
    test_random_signals(12, 80);
    test_output_backpressure();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
